[src/drbv_pkg.sv]
// Shared constants, types and helpers for the dynamic rank bit vector.
// Used by drbv_front, drbv_back and dynamic_rank_bit_vector.
`default_nettype none
package drbv_pkg;

  localparam int NUM_BITS   = 4096;
  localparam int NUM_BLOCKS = 129;
  localparam int IDX_W      = 13;
  localparam int CNT_W      = 13;
  localparam int WORD_BITS  = 32;
  localparam int OFS_W      = $clog2(WORD_BITS);
  localparam int BLK_W      = $clog2(NUM_BLOCKS);
  localparam int MEM_DEPTH  = NUM_BLOCKS - 1;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);
  localparam int FEN_W      = BLK_W + 1;
  localparam int POP_W      = OFS_W + 1;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = Q_PTR_W + 1;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  localparam logic FUNC_QUERY = 1'b0;
  localparam logic FUNC_FLIP  = 1'b1;

  typedef struct packed {
    logic             flip;
    logic             in_range;
    logic [BLK_W-1:0] word;
    logic [OFS_W-1:0] ofs;
  } drbv_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_URD,
    ST_UWR,
    ST_QRY,
    ST_OUT
  } drbv_state_t;

  function automatic logic [POP_W-1:0] popcount32(input logic [WORD_BITS-1:0] x);
    logic [POP_W-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      n = n + POP_W'(x[i]);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

[src/dynamic_rank_bit_vector.sv]
// Top level of the dynamic rank bit vector: front decoder/queue and back
// sequencer with bit-word and Fenwick count stores. Depends on drbv_pkg.
//
//  channel | dir | tdata (low bit up)              | tuser
//  in_     | in  | bit_index[12:0], 3'b0           | func
//  out_    | out | rank_count[12:0], bit_value, 0 | -
//
// The back end takes one transaction at a time. A query reads one Fenwick
// count node per set bit of the word number (at most 7); a flip first updates
// its Fenwick update nodes (at most 8), each with a read and a write, then runs the query.
// Reset clears the queue, the sequencer and the per-entry valid bits; the
// stores read as zero until written, with no clearing pass.
// The queue takes up to two transactions while the back end works or the
// output register waits on out_tready.
`default_nettype none
module dynamic_rank_bit_vector
  import drbv_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [12:0] bit_index
  input  wire logic                  in_tuser,   // [0] func
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata   // [12:0] rank_count, [13] bit_value
);

  logic      cmd_valid;
  logic      cmd_ready;
  drbv_cmd_t cmd;

  drbv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  drbv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

[src/drbv_front.sv]
// Front end: accepts input transactions, clamps and splits the bit index,
// and holds decoded commands in a two-entry queue. Depends on drbv_pkg.
`default_nettype none
module drbv_front
  import drbv_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,   // [12:0] bit_index
  input  wire logic                 in_tuser,   // [0] func
  output logic                      cmd_valid,
  input  wire logic                 cmd_ready,
  output drbv_cmd_t                 cmd
);

  drbv_cmd_t            q_mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]     idx_raw;
  logic [IDX_W-1:0]     idx_c;
  logic                 in_range;
  drbv_cmd_t            dec;
  logic                 push, pop;

  always_comb begin
    idx_raw      = in_tdata[IDX_W-1:0];
    in_range     = idx_raw < IDX_W'(NUM_BITS);
    idx_c        = in_range ? idx_raw : IDX_W'(NUM_BITS);
    dec.flip     = (in_tuser == FUNC_FLIP) && in_range;
    dec.in_range = in_range;
    dec.word     = idx_c[OFS_W +: BLK_W];
    dec.ofs      = idx_c[OFS_W-1:0];
  end

  assign in_tready = cnt_r < Q_CNT_W'(Q_DEPTH);
  assign cmd_valid = cnt_r != '0;
  assign cmd       = q_mem_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec;
    end
  end

endmodule
`default_nettype wire

[src/drbv_back.sv]
// Back end: bit-word memory, Fenwick count memory, update and prefix walks,
// and the output register. Depends on drbv_pkg.
`default_nettype none
module drbv_back
  import drbv_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cmd_valid,
  output logic                       cmd_ready,
  input  drbv_cmd_t                  cmd,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  logic [WORD_BITS-1:0] word_mem [MEM_DEPTH];
  logic [CNT_W-1:0]     tree_mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] word_vld_r;
  logic [MEM_DEPTH-1:0] tree_vld_r;

  drbv_state_t          state_r, state_nxt;
  drbv_cmd_t            cmd_r, cmd_nxt;
  logic                 bit_r, bit_nxt;
  logic [POP_W-1:0]     part_r, part_nxt;
  logic [CNT_W-1:0]     acc_r, acc_nxt;
  logic [FEN_W-1:0]     fen_r, fen_nxt;
  logic [BLK_W-1:0]     q_r, q_nxt;
  logic                 pend_r, pend_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [WORD_BITS-1:0] word_q_r;
  logic                 word_qv_r;
  logic [CNT_W-1:0]     tree_q_r;
  logic                 tree_qv_r;

  logic [ADDR_W-1:0]    word_raddr, word_waddr;
  logic                 word_we;
  logic [WORD_BITS-1:0] word_wdata;
  logic [ADDR_W-1:0]    tree_raddr, tree_waddr;
  logic                 tree_we;
  logic [CNT_W-1:0]     tree_wdata;

  logic [WORD_BITS-1:0] wcur, wnew, below_mask;
  logic [CNT_W-1:0]     tcur;
  logic [FEN_W-1:0]     fen_step;

  always_comb begin
    wcur       = word_qv_r ? word_q_r : '0;
    tcur       = tree_qv_r ? tree_q_r : '0;
    below_mask = ~({WORD_BITS{1'b1}} << cmd_r.ofs);
    wnew       = cmd_r.flip ? (wcur ^ (WORD_BITS'(1) << cmd_r.ofs)) : wcur;
    fen_step   = fen_r + (fen_r & (~fen_r + 1'b1));
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    bit_nxt       = bit_r;
    part_nxt      = part_r;
    acc_nxt       = acc_r;
    fen_nxt       = fen_r;
    q_nxt         = q_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    cmd_ready     = 1'b0;
    word_raddr    = cmd.word[ADDR_W-1:0];
    word_we       = 1'b0;
    word_waddr    = cmd_r.word[ADDR_W-1:0];
    word_wdata    = wnew;
    tree_raddr    = '0;
    tree_we       = 1'b0;
    tree_waddr    = ADDR_W'(fen_r - 1'b1);
    tree_wdata    = bit_r ? tcur + 1'b1 : tcur - 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd_nxt   = cmd;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        bit_nxt  = wnew[cmd_r.ofs] && cmd_r.in_range;
        part_nxt = popcount32(wcur & below_mask);
        q_nxt    = cmd_r.word;
        acc_nxt  = '0;
        pend_nxt = 1'b0;
        fen_nxt  = FEN_W'(cmd_r.word) + 1'b1;
        if (cmd_r.flip) begin
          word_we   = 1'b1;
          state_nxt = ST_URD;
        end else begin
          state_nxt = ST_QRY;
        end
      end
      ST_URD: begin
        tree_raddr = ADDR_W'(fen_r - 1'b1);
        state_nxt  = ST_UWR;
      end
      ST_UWR: begin
        tree_we = 1'b1;
        fen_nxt = fen_step;
        if (fen_step < FEN_W'(NUM_BLOCKS)) begin
          state_nxt = ST_URD;
        end else begin
          state_nxt = ST_QRY;
        end
      end
      ST_QRY: begin
        if (pend_r) begin
          acc_nxt = acc_r + tcur;
        end
        if (q_r != '0) begin
          tree_raddr = ADDR_W'(q_r - 1'b1);
          q_nxt      = q_r - (q_r & (~q_r + 1'b1));
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{(OUT_DATA_W-CNT_W-1){1'b0}}, bit_r, acc_r + CNT_W'(part_r)};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      word_vld_r  <= '0;
      tree_vld_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      if (word_we) begin
        word_vld_r[word_waddr] <= 1'b1;
      end
      if (tree_we) begin
        tree_vld_r[tree_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    bit_r      <= bit_nxt;
    part_r     <= part_nxt;
    acc_r      <= acc_nxt;
    fen_r      <= fen_nxt;
    q_r        <= q_nxt;
    out_data_r <= out_data_nxt;
  end

  // word store
  always_ff @(posedge clk) begin
    if (word_we) begin
      word_mem[word_waddr] <= word_wdata;
    end
    word_q_r  <= word_mem[word_raddr];
    word_qv_r <= word_vld_r[word_raddr];
  end

  // Fenwick count store
  always_ff @(posedge clk) begin
    if (tree_we) begin
      tree_mem[tree_waddr] <= tree_wdata;
    end
    tree_q_r  <= tree_mem[tree_raddr];
    tree_qv_r <= tree_vld_r[tree_raddr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_upd_node_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UWR) |-> (fen_r != '0 && fen_r < FEN_W'(NUM_BLOCKS)))
    else $error("Fenwick update node out of range");

  a_qry_descends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_QRY && $past(state_r) == ST_QRY) |-> (q_r <= $past(q_r)))
    else $error("prefix walk index increased");

  a_word_wr_flip: assert property (@(posedge clk) disable iff (!rst_n)
    word_we |-> (cmd_r.flip && cmd_r.in_range && state_r == ST_MOD))
    else $error("word store written outside an in-range flip");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == ST_OUT))
    else $error("result presented without completing the walk");

endmodule
`default_nettype wire
